[hdl/pidm_pkg.sv]
// Shared types and constants for the PID position motor drive.
// Payload structs, sequencer codes, register indexes and MAC control.
// No dependencies.
package pidm_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int DRIVE_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_FACTOR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_DIR = 3'd4;

   localparam logic [23:0] GEAR_RESET = 24'h010000;  // 1.0 in Q8.16
   localparam logic [7:0]  DUTY_MAX   = 8'd255;

   typedef struct packed {
      logic signed [31:0] encoder_count;
      logic signed [31:0] desired_angle;
   } req_type;

   typedef struct packed {
      logic [7:0] duty;
      logic       direction;
      logic       clamped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_ANGLE,
      ST_ERROR,
      ST_INTEG,
      ST_MAG,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      TERM_ANGLE,
      TERM_P,
      TERM_I,
      TERM_D
   } term_type;

   typedef struct packed {
      logic clear;     // zero the accumulator
      logic mul_en;    // load the product register
      logic acc_en;    // add the product into the accumulator
      logic hi_digit;  // product belongs to the upper 32-bit digit
      logic subtract;  // subtract instead of add
   } mac_ctrl_type;

endpackage

[hdl/pidm_mac.sv]
// Shared multiply-accumulate unit: 33x25 signed multiply, registered,
// then a wide add or subtract into the accumulator, optionally shifted by 32.
// Depends on pidm_pkg.
module pidm_mac #(
   parameter int ACC_W = 83
) (
   input  logic                     clock,
   input  pidm_pkg::mac_ctrl_type   ctrl,
   input  logic signed [32:0]       mul_a,
   input  logic [23:0]              mul_b,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [57:0]      prod_ff;
   logic signed [57:0]      prod_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] addend;

   assign prod_in = mul_a * $signed({1'b0, mul_b});

   always_comb begin
      addend = ACC_W'(prod_ff);
      if (ctrl.hi_digit) begin
         addend = addend <<< 32;
      end
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = ctrl.subtract ? (acc_ff - addend) : (acc_ff + addend);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[hdl/pid_position_motor_drive.sv]
// PID position controller for a geared motor. One request is one control tick and yields
// one response. The single 33x25 multiplier computes the shaft angle and the three PID
// terms one 32-bit digit at a time, each digit a multiply step and an accumulate step.
// req_ready is high only while the sequencer is idle; a finished response sits in an
// output register, so the next request is taken while it waits. The integral saturates
// at INTEGRAL_WIDTH, is held on a clamped drive and cleared when the error is under one
// degree. The user must write registers on the csr port only while the block is idle;
// the block itself does not enforce this.
// Depends on pidm_pkg and pidm_mac.
module pid_position_motor_drive #(
   parameter int ANGLE_WIDTH    = 32,
   parameter int INTEGRAL_WIDTH = 48,
   parameter int DRIVE_LIMIT    = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pidm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pidm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pidm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pidm_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int OP_MAX = (INTEGRAL_WIDTH > ANGLE_WIDTH) ? INTEGRAL_WIDTH : ANGLE_WIDTH;
   localparam int ACC_W  = (OP_MAX + 19 > 58) ? OP_MAX + 19 : 58;
   localparam int ND     = (OP_MAX + 31) / 32;
   localparam int Q_W    = ACC_W - 16;
   localparam logic DIG_LAST = (ND > 1);

   localparam logic signed [ACC_W-1:0] ANG_MAX_W =
      $signed({{(ACC_W-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] ANG_MIN_W =
      $signed({{(ACC_W-ANGLE_WIDTH+1){1'b1}}, {(ANGLE_WIDTH-1){1'b0}}});
   localparam logic signed [ACC_W-1:0] INT_MAX_W =
      $signed({{(ACC_W-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] INT_MIN_W =
      $signed({{(ACC_W-INTEGRAL_WIDTH+1){1'b1}}, {(INTEGRAL_WIDTH-1){1'b0}}});
   localparam logic signed [ANGLE_WIDTH-1:0] DEG_POS = ANGLE_WIDTH'(256);
   localparam logic signed [ANGLE_WIDTH-1:0] DEG_NEG = -DEG_POS;

   function automatic logic signed [ANGLE_WIDTH-1:0] sat_angle(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > ANG_MAX_W) begin
         r = ANG_MAX_W;
      end else if (v < ANG_MIN_W) begin
         r = ANG_MIN_W;
      end
      return r[ANGLE_WIDTH-1:0];
   endfunction

   function automatic logic signed [INTEGRAL_WIDTH-1:0] sat_integ(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > INT_MAX_W) begin
         r = INT_MAX_W;
      end else if (v < INT_MIN_W) begin
         r = INT_MIN_W;
      end
      return r[INTEGRAL_WIDTH-1:0];
   endfunction

   // configuration
   logic [15:0] prop_gain_ff;
   logic [15:0] integ_gain_ff;
   logic [15:0] deriv_gain_ff;
   logic [23:0] gear_factor_ff;
   logic        reverse_dir_ff;

   // sequencer
   pidm_pkg::state_type   state_ff, state_in;
   pidm_pkg::term_type    term_ff, term_in;
   logic                  dig_ff, dig_in;
   pidm_pkg::mac_ctrl_type mac_ctrl;
   logic                  done_go;

   // datapath
   logic signed [31:0]               count_ff;
   logic signed [31:0]               desired_ff;
   logic signed [ANGLE_WIDTH-1:0]    dsat_ff;
   logic signed [ANGLE_WIDTH-1:0]    angle_ff;
   logic signed [ANGLE_WIDTH-1:0]    prev_ff;
   logic signed [ANGLE_WIDTH-1:0]    err_ff;
   logic signed [ANGLE_WIDTH-1:0]    vel_ff;
   logic signed [INTEGRAL_WIDTH-1:0] integ_ff;
   logic signed [INTEGRAL_WIDTH-1:0] int_new_ff;
   logic [ACC_W-1:0]                 mag_ff;
   logic                             neg_ff;
   logic signed [ACC_W-1:0]          acc;

   logic                  rsp_valid_ff;
   pidm_pkg::rsp_type     rsp_data_ff;

   // operand and gain selection for the shared multiplier
   logic signed [63:0] op64;
   logic [31:0]        digit;
   logic signed [32:0] mul_a;
   logic [23:0]        mul_b;

   always_comb begin
      case (term_ff)
         pidm_pkg::TERM_ANGLE: begin
            op64  = 64'(count_ff);
            mul_b = gear_factor_ff;
         end
         pidm_pkg::TERM_P: begin
            op64  = 64'(err_ff);
            mul_b = {8'd0, prop_gain_ff};
         end
         pidm_pkg::TERM_I: begin
            op64  = 64'(int_new_ff);
            mul_b = {8'd0, integ_gain_ff};
         end
         pidm_pkg::TERM_D: begin
            op64  = 64'(vel_ff);
            mul_b = {8'd0, deriv_gain_ff};
         end
         default: begin
            op64  = '0;
            mul_b = '0;
         end
      endcase
      digit = dig_ff ? op64[63:32] : op64[31:0];
      // only the top digit carries the sign
      mul_a = $signed({(dig_ff == DIG_LAST) ? digit[31] : 1'b0, digit});
   end

   pidm_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .acc   (acc)
   );

   // next state and control
   always_comb begin
      state_in  = state_ff;
      term_in   = term_ff;
      dig_in    = dig_ff;
      mac_ctrl  = '0;
      req_ready = 1'b0;
      done_go   = 1'b0;
      case (state_ff)
         pidm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mac_ctrl.clear = 1'b1;
               term_in  = pidm_pkg::TERM_ANGLE;
               dig_in   = 1'b0;
               state_in = pidm_pkg::ST_MUL;
            end
         end
         pidm_pkg::ST_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            state_in = pidm_pkg::ST_ACC;
         end
         pidm_pkg::ST_ACC: begin
            mac_ctrl.acc_en   = 1'b1;
            mac_ctrl.hi_digit = dig_ff;
            mac_ctrl.subtract = (term_ff == pidm_pkg::TERM_D);
            if (dig_ff != DIG_LAST) begin
               dig_in   = 1'b1;
               state_in = pidm_pkg::ST_MUL;
            end else begin
               dig_in = 1'b0;
               case (term_ff)
                  pidm_pkg::TERM_ANGLE: state_in = pidm_pkg::ST_ANGLE;
                  pidm_pkg::TERM_P: begin
                     term_in  = pidm_pkg::TERM_I;
                     state_in = pidm_pkg::ST_MUL;
                  end
                  pidm_pkg::TERM_I: begin
                     term_in  = pidm_pkg::TERM_D;
                     state_in = pidm_pkg::ST_MUL;
                  end
                  pidm_pkg::TERM_D: state_in = pidm_pkg::ST_MAG;
                  default:          state_in = pidm_pkg::ST_IDLE;
               endcase
            end
         end
         pidm_pkg::ST_ANGLE: state_in = pidm_pkg::ST_ERROR;
         pidm_pkg::ST_ERROR: state_in = pidm_pkg::ST_INTEG;
         pidm_pkg::ST_INTEG: begin
            mac_ctrl.clear = 1'b1;
            term_in  = pidm_pkg::TERM_P;
            state_in = pidm_pkg::ST_MUL;
         end
         pidm_pkg::ST_MAG: state_in = pidm_pkg::ST_DONE;
         pidm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               done_go  = 1'b1;
               state_in = pidm_pkg::ST_IDLE;
            end
         end
         default: state_in = pidm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidm_pkg::ST_IDLE;
         term_ff  <= pidm_pkg::TERM_ANGLE;
         dig_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         dig_ff   <= dig_in;
      end
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         gear_factor_ff <= pidm_pkg::GEAR_RESET;
         reverse_dir_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            pidm_pkg::CSR_PROP_GAIN:   prop_gain_ff   <= csr_data[15:0];
            pidm_pkg::CSR_INTEG_GAIN:  integ_gain_ff  <= csr_data[15:0];
            pidm_pkg::CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_data[15:0];
            pidm_pkg::CSR_GEAR_FACTOR: gear_factor_ff <= csr_data;
            pidm_pkg::CSR_REVERSE_DIR: reverse_dir_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // drive quantization and result
   logic [Q_W-1:0]                q_drive;
   logic                          clamp;
   logic [pidm_pkg::DRIVE_W-1:0]  mag_drive;
   logic                          neg_eff;
   pidm_pkg::rsp_type             rsp_in;

   always_comb begin
      q_drive   = mag_ff[ACC_W-1:16];
      clamp     = q_drive > Q_W'(DRIVE_LIMIT);
      mag_drive = clamp ? pidm_pkg::DRIVE_W'(DRIVE_LIMIT) : q_drive[pidm_pkg::DRIVE_W-1:0];
      neg_eff   = neg_ff && (mag_drive != '0);  // zero drive counts as forward
      rsp_in.duty      = (mag_drive > pidm_pkg::DRIVE_W'(pidm_pkg::DUTY_MAX)) ?
                         pidm_pkg::DUTY_MAX : mag_drive[7:0];
      rsp_in.direction = ~neg_eff ^ reverse_dir_ff;
      rsp_in.clamped   = clamp;
   end

   // datapath payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         count_ff   <= req_data.encoder_count;
         desired_ff <= req_data.desired_angle;
      end
      if (state_ff == pidm_pkg::ST_ANGLE) begin
         angle_ff <= sat_angle(acc >>> 8);
         dsat_ff  <= sat_angle(ACC_W'(desired_ff));
      end
      if (state_ff == pidm_pkg::ST_ERROR) begin
         err_ff <= sat_angle(ACC_W'(dsat_ff) - ACC_W'(angle_ff));
         vel_ff <= sat_angle(ACC_W'(angle_ff) - ACC_W'(prev_ff));
      end
      if (state_ff == pidm_pkg::ST_INTEG) begin
         int_new_ff <= sat_integ(ACC_W'(integ_ff) + ACC_W'(err_ff));
      end
      if (state_ff == pidm_pkg::ST_MAG) begin
         neg_ff <= acc[ACC_W-1];
         mag_ff <= acc[ACC_W-1] ? $unsigned(-acc) : $unsigned(acc);
      end
      if (done_go) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // loop state and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
            prev_ff      <= angle_ff;
            if (err_ff > DEG_NEG && err_ff < DEG_POS) begin
               integ_ff <= '0;
            end else if (!clamp) begin
               integ_ff <= int_new_ff;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/pidm_checker.sv]
// Port-level checks for the PID position motor drive, bound to the top level.
// Depends on pidm_pkg and pid_position_motor_drive.
module pidm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pidm_pkg::rsp_type rsp_data
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // one tick at a time: no request right after a request transfer
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a tick is in progress");

   // a new response comes only out of a busy sequencer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a tick in progress");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind pid_position_motor_drive pidm_checker u_pidm_checker (.*);
